FILE: src/progressive_mesh_lod_patcher_assert.svh
// assertion macros used by the checker
`ifndef PROGRESSIVE_MESH_LOD_PATCHER_ASSERT_SVH
`define PROGRESSIVE_MESH_LOD_PATCHER_ASSERT_SVH

// same-cycle implication
`define PMLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmlp assertion failed");

// next-cycle implication
`define PMLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmlp assertion failed");

`endif

FILE: src/pmlp_pkg.sv
package pmlp_pkg;

    localparam int MaxSplits   = 4096;
    localparam int MaxFixSlots = 16384;
    localparam int MaxIndices  = 65536;

    localparam int SplitAw = $clog2(MaxSplits);
    localparam int FixAw   = $clog2(MaxFixSlots);
    localparam int IndexAw = $clog2(MaxIndices);

    localparam int InWidth  = 104;
    localparam int OutWidth = 56;

    // reciprocal of three for a 20-bit dividend, shift 21
    localparam logic [19:0] RecipThree = 20'hAAAAB;

    typedef enum logic [2:0] {
        OP_LOAD_SPLIT = 3'd0,
        OP_LOAD_FIX   = 3'd1,
        OP_LOAD_INDEX = 3'd2,
        OP_TICK       = 3'd3,
        OP_READ_INDEX = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        REG_TOTAL  = 2'd0,
        REG_MIN    = 2'd1,
        REG_START  = 2'd2,
        REG_PERIOD = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_MUL,
        ST_TARGET,
        ST_CHECK,
        ST_FETCH,
        ST_PATCH,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

FILE: src/pmlp_ram.sv
module pmlp_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/progressive_mesh_lod_patcher.sv
// a level update walks the split records one by one and patches the fix slots of each,
// with the fix count of a record capped at 32768
// one request at a time; the next is taken once the result sits in the output register
// the split, fix-slot and index memories are not cleared on reset
// reset loads counts from the register reset values and clears the refresh phase
module progressive_mesh_lod_patcher
    import pmlp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode, slot, split_vertex, new_triangles, fix_faces, entry_value, lod_level
    input  logic [InWidth-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_value, vertex_count, triangle_count, draw_enable, lod_applied
    output logic [OutWidth-1:0] m_tdata,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [19:0]         cfg_wdata
);

    // input fields
    logic [2:0]  in_op;
    logic [15:0] in_slot, in_vert, in_tri, in_fix, in_val;
    logic [17:0] in_lod;
    assign in_op   = s_tdata[2:0];
    assign in_slot = s_tdata[18:3];
    assign in_vert = s_tdata[34:19];
    assign in_tri  = s_tdata[50:35];
    assign in_fix  = s_tdata[66:51];
    assign in_val  = s_tdata[82:67];
    assign in_lod  = s_tdata[100:83];

    state_t state_reg, state_next;
    logic [15:0] total_reg, min_reg, cur_v_reg, cur_v_next;
    logic [19:0] cur_i_reg, cur_i_next;
    logic [8:0]  period_reg;
    logic [14:0] cursor_reg, cursor_next;
    logic [7:0]  rcnt_reg, rcnt_next;
    logic        applied_reg, applied_next;
    logic [15:0] rd_reg, rd_next;
    logic [16:0] level_reg, level_next;
    logic [32:0] prod_reg, prod_next;
    logic [16:0] tgt_reg, tgt_next;
    logic        fwd_reg, fwd_next, svalid_reg, svalid_next;
    logic [15:0] tri_reg, tri_next, fix_reg, fix_next, n_reg, n_next, k_reg, k_next;
    logic [15:0] val_reg, val_next;
    logic [14:0] pos0_reg, pos0_next;
    logic        pvld_reg, pvld_next;
    logic        out_valid_reg, out_valid_next;
    logic [OutWidth-1:0] out_reg, out_next;

    logic        accept;
    logic [8:0]  period_eff, rcnt_inc;
    logic [15:0] fetch_v, fetch_r;
    logic [14:0] patch_pos;
    logic        issue;
    logic [39:0] div_prod;
    logic [18:0] tri_cnt;
    logic [17:0] tri3;

    // memory ports
    logic                split_we, fix_we, idx_we;
    logic [SplitAw-1:0]  split_raddr;
    logic [47:0]         split_rdata;
    logic [15:0]         fix_rdata, idx_rdata;
    logic [IndexAw-1:0]  idx_waddr;
    logic [15:0]         idx_wdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign period_eff = (period_reg > 9'd256) ? 9'd256 : period_reg;
    assign rcnt_inc   = {1'b0, rcnt_reg} + 9'd1;
    assign patch_pos  = pos0_reg + k_reg[14:0];
    assign issue      = (k_reg < n_reg);
    assign tri3       = {2'b00, tri_reg} + {1'b0, tri_reg, 1'b0};
    assign div_prod   = cur_i_reg * RecipThree;
    assign tri_cnt    = div_prod[39:21];

    // split record address for the vertex being walked
    always_comb
    begin
        fetch_v = (cur_v_reg < tgt_reg) ? cur_v_reg : (cur_v_reg - 16'd1);
        fetch_r = fetch_v - min_reg;
    end
    assign split_raddr = fetch_r[SplitAw-1:0];

    // store writes
    assign split_we = accept && (in_op == OP_LOAD_SPLIT) && (in_slot < 16'(MaxSplits));
    assign fix_we   = accept && (in_op == OP_LOAD_FIX) && ({1'b0, in_slot} < 17'(MaxFixSlots));
    assign idx_we   = (accept && (in_op == OP_LOAD_INDEX)) || pvld_reg;
    assign idx_waddr = pvld_reg ? fix_rdata[IndexAw-1:0] : in_slot[IndexAw-1:0];
    assign idx_wdata = pvld_reg ? val_reg : in_val;

    pmlp_ram #(.Width(48), .Depth(MaxSplits)) u_split_ram (
        .clk  (clk),
        .we   (split_we),
        .waddr(in_slot[SplitAw-1:0]),
        .wdata({in_fix, in_tri, in_vert}),
        .raddr(split_raddr),
        .rdata(split_rdata)
    );

    pmlp_ram #(.Width(16), .Depth(MaxFixSlots)) u_fix_ram (
        .clk  (clk),
        .we   (fix_we),
        .waddr(in_slot[FixAw-1:0]),
        .wdata(in_val),
        .raddr(patch_pos[FixAw-1:0]),
        .rdata(fix_rdata)
    );

    pmlp_ram #(.Width(16), .Depth(MaxIndices)) u_index_ram (
        .clk  (clk),
        .we   (idx_we),
        .waddr(idx_waddr),
        .wdata(idx_wdata),
        .raddr(in_slot[IndexAw-1:0]),
        .rdata(idx_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_READ_INDEX)
                        state_next = ST_RDWAIT;
                    else if (in_op == OP_TICK && rcnt_inc >= period_eff && !in_lod[17])
                        state_next = ST_MUL;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RDWAIT: state_next = ST_DONE;
            ST_MUL:    state_next = ST_TARGET;
            ST_TARGET: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if ({1'b0, cur_v_reg} != tgt_reg)
                    state_next = ST_FETCH;
                else
                    state_next = ST_DONE;
            end
            ST_FETCH:  state_next = ST_PATCH;
            ST_PATCH:
            begin
                if (!issue && !pvld_reg)
                    state_next = ST_STEP;
            end
            ST_STEP:   state_next = ST_CHECK;
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cur_v_next     = cur_v_reg;
        cur_i_next     = cur_i_reg;
        cursor_next    = cursor_reg;
        rcnt_next      = rcnt_reg;
        applied_next   = applied_reg;
        rd_next        = rd_reg;
        level_next     = level_reg;
        prod_next      = prod_reg;
        tgt_next       = tgt_reg;
        fwd_next       = fwd_reg;
        svalid_next    = svalid_reg;
        tri_next       = tri_reg;
        fix_next       = fix_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        val_next       = val_reg;
        pos0_next      = pos0_reg;
        pvld_next      = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_next      = 16'd0;
                    applied_next = 1'b0;
                    level_next   = (in_lod > 18'sd65536) ? 17'h10000 : in_lod[16:0];
                    if (in_op == OP_TICK)
                    begin
                        if (rcnt_inc >= period_eff)
                        begin
                            rcnt_next    = 8'd0;
                            applied_next = !in_lod[17];
                        end
                        else
                            rcnt_next = rcnt_inc[7:0];
                    end
                end
            end
            ST_RDWAIT: rd_next = idx_rdata;
            ST_MUL:
            begin
                prod_next = ((total_reg > min_reg) ? (total_reg - min_reg) : 16'd0) * level_reg;
            end
            ST_TARGET:
            begin
                tgt_next = {1'b0, min_reg} + 17'((prod_reg + 33'd32767) >> 16);
            end
            ST_CHECK:
            begin
                fwd_next    = ({1'b0, cur_v_reg} < tgt_reg);
                svalid_next = (fetch_v >= min_reg) && (fetch_r < 16'(MaxSplits));
                if ({1'b0, cur_v_reg} > tgt_reg)
                    cur_v_next = cur_v_reg - 16'd1;
            end
            ST_FETCH:
            begin
                tri_next  = svalid_reg ? split_rdata[31:16] : 16'd0;
                fix_next  = svalid_reg ? split_rdata[47:32] : 16'd0;
                n_next    = (fix_next > 16'd32768) ? 16'd32768 : fix_next;
                k_next    = 16'd0;
                pos0_next = fwd_reg ? cursor_reg : (cursor_reg - fix_next[14:0]);
                val_next  = fwd_reg ? cur_v_reg : (svalid_reg ? split_rdata[15:0] : 16'd0);
            end
            ST_PATCH:
            begin
                // read one fix slot a cycle, write its index the cycle after
                if (issue)
                begin
                    k_next    = k_reg + 16'd1;
                    pvld_next = ({1'b0, patch_pos} < 16'(MaxFixSlots));
                end
            end
            ST_STEP:
            begin
                if (fwd_reg)
                begin
                    cur_i_next  = cur_i_reg + {2'b00, tri3};
                    cur_v_next  = cur_v_reg + 16'd1;
                    cursor_next = cursor_reg + fix_reg[14:0];
                end
                else
                begin
                    cur_i_next  = cur_i_reg - {2'b00, tri3};
                    cursor_next = cursor_reg - fix_reg[14:0];
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next = {3'b000, applied_reg,
                                (cur_v_reg != 16'd0) && (cur_i_reg != 20'd0),
                                tri_cnt, cur_v_reg, rd_reg};
                end
            end
            default: ;
        endcase

        // register writes take effect on the counts
        if (cfg_wr_en && cfg_addr == REG_MIN)
        begin
            cur_v_next  = cfg_wdata[15:0];
            cursor_next = 15'd0;
        end
        if (cfg_wr_en && cfg_addr == REG_START)
            cur_i_next = cfg_wdata;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= 16'd1;
            min_reg       <= 16'd0;
            period_reg    <= 9'd1;
            cur_v_reg     <= 16'd0;
            cur_i_reg     <= 20'd0;
            cursor_reg    <= 15'd0;
            rcnt_reg      <= 8'd0;
            pvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_v_reg     <= cur_v_next;
            cur_i_reg     <= cur_i_next;
            cursor_reg    <= cursor_next;
            rcnt_reg      <= rcnt_next;
            pvld_reg      <= pvld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_TOTAL:  total_reg  <= cfg_wdata[15:0];
                    REG_MIN:    min_reg    <= cfg_wdata[15:0];
                    REG_START:  ;
                    REG_PERIOD: period_reg <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        applied_reg <= applied_next;
        rd_reg      <= rd_next;
        level_reg   <= level_next;
        prod_reg    <= prod_next;
        tgt_reg     <= tgt_next;
        fwd_reg     <= fwd_next;
        svalid_reg  <= svalid_next;
        tri_reg     <= tri_next;
        fix_reg     <= fix_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        val_reg     <= val_next;
        pos0_reg    <= pos0_next;
        out_reg     <= out_next;
    end

endmodule

FILE: src/pmlp_checker.sv
`include "progressive_mesh_lod_patcher_assert.svh"

module pmlp_checker
    import pmlp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [OutWidth-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready
);

    // a stalled result stays offered
    `PMLP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // one request at a time
    `PMLP_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // no drawing without vertices
    `PMLP_ASSERT_IMP(a_draw_needs_verts, m_tvalid && m_tdata[31:16] == 16'd0, !m_tdata[51])

    // level update never carries read data
    `PMLP_ASSERT_IMP(a_applied_no_read, m_tvalid && m_tdata[52], m_tdata[15:0] == 16'd0)

endmodule

bind progressive_mesh_lod_patcher pmlp_checker u_pmlp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
